>>> design/asbvp_pkg.sv
// ----------------------------------------------------------------------------
// asbvp_pkg: shared types and constants of the signed byte value parser
// parse phases, status codes and character codes
// ----------------------------------------------------------------------------
package asbvp_pkg;

  localparam int ByteW   = 8;
  localparam int StatusW = 3;
  localparam int MagW    = 9;
  // wide enough for 256 * 10 + 9
  localparam int MagProdW = 12;

  localparam logic [MagW-1:0] MagSat  = MagW'(256);
  localparam logic [MagW-1:0] ByteMax = MagW'(8'hff);

  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChPlus  = 8'h2b;
  localparam logic [ByteW-1:0] ChMinus = 8'h2d;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;

  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_DIGIT = 3'd1,
    PH_TRAIL = 3'd2,
    PH_JUNK  = 3'd3,
    PH_NOINT = 3'd4
  } phase_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_NOINT    = 3'd1,
    ST_TRAILING = 3'd2,
    ST_NEGATIVE = 3'd3,
    ST_ABOVE    = 3'd4
  } status_t;

endpackage

>>> design/ascii_signed_byte_value_parser.sv
// ----------------------------------------------------------------------------
// ascii_signed_byte_value_parser: ascii decimal to unsigned byte
// scans one message a character per word and reports value and status on
// the terminator word
// ----------------------------------------------------------------------------
//
//  channel   ports                               direction  words
//  in        in_valid in_ready in_byte_req in_last  input   one per character
//  out       out_valid out_ready out_value out_status output one per message
//
// one input word is taken every cycle while in_ready is high; a terminator
// word passes the input register, then the result register, once accepted
// the parse state (phase, sign, number flag, magnitude) updates as a word
// leaves the input register; non-terminator words never wait on each other
// in_ready drops only while the input register holds a terminator word and a
// previous result is still waiting on out_ready
// rst_n is synchronous, active low, and returns the parser to leading spaces
// ----------------------------------------------------------------------------
module ascii_signed_byte_value_parser
  import asbvp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ByteW-1:0]   in_byte_req,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ByteW-1:0]   out_value,
  output logic [StatusW-1:0] out_status
);

  // input register
  logic             s1_valid_r;
  logic [ByteW-1:0] s1_byte_r;
  logic             s1_last_r;

  // parse state
  phase_t          phase_r, phase_nxt;
  logic            minus_r, minus_nxt;
  logic            number_r, number_nxt;
  logic [MagW-1:0] mag_r, mag_nxt;

  // result register
  logic               out_valid_r;
  logic [ByteW-1:0]   out_value_r, out_value_nxt;
  status_t            out_status_r, out_status_nxt;

  logic              out_free;
  logic              s1_adv;
  logic              ch_digit;
  logic [MagW-1:0]   digit_mag;
  logic [MagProdW-1:0] mag_prod;

  // a non-terminator word never needs the output slot
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready = !s1_valid_r || s1_adv;

  assign ch_digit = (s1_byte_r >= ChZero) && (s1_byte_r <= ChNine);

  // magnitude * 10 + digit, saturating at 256
  assign mag_prod  = ({mag_r, 3'b000} + {2'b00, mag_r, 1'b0})
                   + MagProdW'(s1_byte_r - ChZero);
  assign digit_mag = (mag_prod > MagProdW'(MagSat)) ? MagSat : mag_prod[MagW-1:0];

  // next parse state and result
  always_comb begin
    phase_nxt      = phase_r;
    minus_nxt      = minus_r;
    number_nxt     = number_r;
    mag_nxt        = mag_r;
    out_value_nxt  = '0;
    out_status_nxt = ST_OK;

    if (s1_last_r) begin
      // status priority: no integer, trailing data, negative, above 255
      if (!number_r || phase_r == PH_NOINT) begin
        out_status_nxt = ST_NOINT;
      end else if (phase_r == PH_JUNK) begin
        out_status_nxt = ST_TRAILING;
      end else if (minus_r && mag_r != '0) begin
        out_status_nxt = ST_NEGATIVE;
      end else if (mag_r > ByteMax) begin
        out_status_nxt = ST_ABOVE;
      end else begin
        out_status_nxt = ST_OK;
        out_value_nxt  = mag_r[ByteW-1:0];
      end
      // back to the reset state for the next message
      phase_nxt  = PH_LEAD;
      minus_nxt  = 1'b0;
      number_nxt = 1'b0;
      mag_nxt    = '0;
    end else begin
      case (phase_r)
        PH_LEAD: begin
          if (s1_byte_r == ChSpace) begin
            phase_nxt = PH_LEAD;
          end else if (s1_byte_r == ChPlus || s1_byte_r == ChMinus) begin
            minus_nxt  = (s1_byte_r == ChMinus);
            number_nxt = 1'b1;
            phase_nxt  = PH_DIGIT;
          end else if (ch_digit) begin
            number_nxt = 1'b1;
            mag_nxt    = digit_mag;
            phase_nxt  = PH_DIGIT;
          end else begin
            phase_nxt = PH_NOINT;
          end
        end
        PH_DIGIT: begin
          if (ch_digit) begin
            mag_nxt = digit_mag;
          end else if (s1_byte_r == ChSpace) begin
            phase_nxt = PH_TRAIL;
          end else begin
            phase_nxt = PH_JUNK;
          end
        end
        PH_TRAIL: begin
          if (s1_byte_r != ChSpace) begin
            phase_nxt = PH_JUNK;
          end
        end
        default: begin
          // junk and no-integer phases hold until the terminator
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte_r <= in_byte_req;
      s1_last_r <= in_last;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEAD;
      minus_r  <= 1'b0;
      number_r <= 1'b0;
      mag_r    <= '0;
    end else if (s1_adv) begin
      phase_r  <= phase_nxt;
      minus_r  <= minus_nxt;
      number_r <= number_nxt;
      mag_r    <= mag_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_adv && s1_last_r) begin
      out_value_r  <= out_value_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

`ifndef SYNTH
  // a result only appears after a terminator word left the input register
  a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv && s1_last_r))
    else $error("result appeared without a terminator word");

  // a terminator word clears the parse state
  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> (phase_r == PH_LEAD && mag_r == '0 &&
                               !minus_r && !number_r))
    else $error("parse state not cleared after terminator");

  // any status other than ok carries a zero value
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> out_value_r == '0)
    else $error("nonzero value with error status");

  // input stalls only behind a blocked terminator word
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s1_last_r && out_valid_r && !out_ready))
    else $error("input stalled without cause");

  // magnitude never exceeds the saturation point
  a_mag_sat: assert property (@(posedge clk) disable iff (!rst_n)
    mag_r <= MagSat)
    else $error("magnitude above saturation");
`endif

endmodule

>>> verif/tb_ascii_signed_byte_value_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ascii_signed_byte_value_parser: self-checking bench of the byte parser
// drives whole reply messages (spaces, sign, digits, spaces, terminator) with
// random idle and stall on both channels, predicts value and status of every
// message in a scoreboard and checks each result word against it in order
// ----------------------------------------------------------------------------
module tb_ascii_signed_byte_value_parser;
  import asbvp_pkg::*;

  // no-progress limit: the worst stall of a 72 % idle side is far below this
  localparam int unsigned StallLimit = 5000;
  // terminator has to pass the input register to reach the output register
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomWords = 1050;

  typedef struct {
    logic [ByteW-1:0] value;
    status_t          status;
  } parse_result_t;

  // ------------------------------------------------------------------
  // scoreboard: tracks the parse state of the message in flight and keeps
  // the verdicts of finished messages until the block reports them
  // ------------------------------------------------------------------
  class parse_scoreboard;
    phase_t           phase;
    bit               minus_seen;
    bit               number_seen;
    logic [MagW-1:0]  magnitude;
    parse_result_t    verdict_q[$];
    int unsigned      mismatches;

    function new();
      mismatches = 0;
      clear_message();
    endfunction

    function void clear_message();
      phase       = PH_LEAD;
      minus_seen  = 1'b0;
      number_seen = 1'b0;
      magnitude   = '0;
    endfunction

    function bit is_digit(logic [ByteW-1:0] ch);
      return ch >= ChZero && ch <= ChNine;
    endfunction

    // decimal shift-in, clamped at the saturation value
    function void take_digit(logic [ByteW-1:0] ch);
      logic [MagProdW-1:0] prod;
      prod = MagProdW'(magnitude) * MagProdW'(10) + MagProdW'(ch - ChZero);
      magnitude = (prod > MagProdW'(MagSat)) ? MagSat : prod[MagW-1:0];
    endfunction

    // called for every accepted input word
    function void note_word(logic [ByteW-1:0] ch, logic last);
      parse_result_t res;
      if (last) begin
        // terminator: the character itself is ignored
        res.value = '0;
        if (!number_seen || phase == PH_NOINT) begin
          res.status = ST_NOINT;
        end else if (phase == PH_JUNK) begin
          res.status = ST_TRAILING;
        end else if (minus_seen && magnitude != '0) begin
          res.status = ST_NEGATIVE;
        end else if (magnitude > ByteMax) begin
          res.status = ST_ABOVE;
        end else begin
          res.status = ST_OK;
          res.value  = magnitude[ByteW-1:0];
        end
        verdict_q.push_back(res);
        clear_message();
        return;
      end
      case (phase)
        PH_LEAD: begin
          if (ch == ChSpace) begin
            // still in leading spaces
          end else if (ch == ChPlus || ch == ChMinus) begin
            minus_seen  = (ch == ChMinus);
            number_seen = 1'b1;
            phase       = PH_DIGIT;
          end else if (is_digit(ch)) begin
            number_seen = 1'b1;
            take_digit(ch);
            phase = PH_DIGIT;
          end else begin
            phase = PH_NOINT;
          end
        end
        PH_DIGIT: begin
          if (is_digit(ch)) begin
            take_digit(ch);
          end else if (ch == ChSpace) begin
            phase = PH_TRAIL;
          end else begin
            phase = PH_JUNK;
          end
        end
        PH_TRAIL: begin
          if (ch != ChSpace) begin
            phase = PH_JUNK;
          end
        end
        default: begin
          // junk and no-integer phases hold until the terminator
        end
      endcase
    endfunction

    // called for every accepted result word
    function void check_result(logic [ByteW-1:0] value, logic [StatusW-1:0] status);
      parse_result_t exp;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected result value %0d status %0d", $realtime, value, status);
        end
        return;
      end
      exp = verdict_q.pop_front();
      if (value !== exp.value || status !== exp.status) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch value exp %0d got %0d, status exp %0d got %0d",
                   $realtime, exp.value, value, exp.status, status);
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [ByteW-1:0]   in_byte_req = '0;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ByteW-1:0]   out_value;
  logic [StatusW-1:0] out_status;

  parse_scoreboard sb = new();

  // idle percentages of sender and receiver, changed between test phases
  int unsigned send_idle_pct = 7;
  int unsigned recv_idle_pct = 72;
  int unsigned words_sent = 0;
  int unsigned stall_cycles = 0;
  // characters of the message about to be sent, terminator excluded
  logic [ByteW-1:0] msg_q[$];

  ascii_signed_byte_value_parser i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte_req(in_byte_req),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .out_status (out_status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver: random backpressure, updated once per cycle on the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // monitor on the rising edge: sees pre-edge values of every handshake
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else begin
      if (in_valid && in_ready) begin
        sb.note_word(in_byte_req, in_last);
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_value, out_status);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // one word on the input channel; valid holds until the handshake
  task automatic send_word(input logic [ByteW-1:0] ch, input logic last);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_byte_req <= ch;
    in_last     <= last;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    words_sent++;
  endtask

  // body of msg_q, then the terminator word
  task automatic send_message(input logic [ByteW-1:0] term);
    foreach (msg_q[i]) begin
      send_word(msg_q[i], 1'b0);
    end
    send_word(term, 1'b1);
  endtask

  task automatic load_text(input string s);
    msg_q.delete();
    for (int i = 0; i < s.len(); i++) begin
      msg_q.push_back(s[i]);
    end
  endtask

  // mostly well-formed messages with random content, some noise and damage
  task automatic build_random_message();
    string digits;
    int    kind;
    msg_q.delete();
    if ($urandom_range(0, 99) < 6) begin
      // pure noise
      repeat ($urandom_range(0, 6)) msg_q.push_back(ByteW'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 3)) msg_q.push_back(ChSpace);
    case ($urandom_range(0, 3))
      0: msg_q.push_back(ChPlus);
      1: msg_q.push_back(ChMinus);
      default: ;
    endcase
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      // spread over 0 to 300, across the 255 / 256 boundary
      digits = $sformatf("%0d", $urandom_range(0, 300));
    end else if (kind <= 7) begin
      digits = $sformatf("%0d", $urandom_range(0, 9));
    end else if (kind == 8) begin
      // long runs drive the magnitude into saturation
      digits = "";
      repeat ($urandom_range(4, 8)) digits = {digits, $sformatf("%0d", $urandom_range(0, 9))};
    end else begin
      digits = "";
    end
    if ($urandom_range(0, 9) == 0) begin
      msg_q.push_back(ChZero);
    end
    for (int i = 0; i < digits.len(); i++) begin
      msg_q.push_back(digits[i]);
    end
    repeat ($urandom_range(0, 2)) msg_q.push_back(ChSpace);
    // damage: overwrite or insert one random character
    kind = $urandom_range(0, 99);
    if (kind < 12 && msg_q.size() != 0) begin
      msg_q[$urandom_range(0, msg_q.size() - 1)] = ByteW'($urandom_range(0, 255));
    end else if (kind < 22) begin
      msg_q.insert($urandom_range(0, msg_q.size()), ByteW'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int unsigned leftover;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed messages
    load_text("");      send_message(8'h00);   // empty: no integer
    load_text("+");     send_message(8'hff);   // lone sign gives ok 0
    load_text("-0");    send_message(8'h0a);   // minus zero is not negative
    load_text("255");   send_message(8'h0d);   // largest ok value
    load_text("-7");    send_message(8'h0a);   // negative
    load_text("9");     msg_q.push_front(8'hff);
    send_message(8'h0a);                        // bad first character
    load_text("1 -");   send_message(ChMinus); // second sign after spaces
    load_text("300");   send_message(ChZero);  // above 255
    load_text(" -");    send_message(8'h0a);   // lone minus after spaces

    // random messages, three idle profiles
    words_sent = 0;
    while (words_sent < RandomWords) begin
      if (words_sent >= 2 * RandomWords / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (words_sent >= RandomWords / 3) begin
        send_idle_pct = 72;
        recv_idle_pct = 7;
      end
      build_random_message();
      send_message(ByteW'($urandom_range(0, 255)));
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then give stray results a chance to show up
    while (sb.verdict_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
    leftover = sb.verdict_q.size();
    if (sb.mismatches == 0 && leftover == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
